FILE: rtl/fbe_pkg.sv
// ----------------------------------------------------------------------------
// fbe_pkg
// shared types, widths, constants and polynomial coefficients of the
// fourier basis evaluator
// ----------------------------------------------------------------------------
package fbe_pkg;

  localparam int MAX_ORDER  = 16;
  localparam int PHASE_BITS = 16;

  localparam int ORDER_W = 5;
  localparam int SCALE_W = 16;
  localparam int PHASE_W = 16;
  localparam int INDEX_W = 6;
  localparam int VALUE_W = 16;
  localparam int DERIV_W = 28;
  localparam int MAG_W   = VALUE_W - 1;
  localparam int ORD_W   = $clog2(MAX_ORDER + 1);
  localparam int KS_W    = SCALE_W + ORD_W;

  localparam int MUL_W   = 31;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int FRAC    = 30;
  localparam int Z_SHIFT = 32 - PHASE_BITS;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_ORDER = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(16);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(256);

  localparam logic [VALUE_W-1:0] ONE_Q14 = VALUE_W'(16384);
  localparam logic [MAG_W-1:0]   ONE_MAG = MAG_W'(16384);

  localparam logic [31:0] COEF1 = 32'd1686629713;
  localparam logic [31:0] COEF3 = 32'd693598668;
  localparam logic [31:0] COEF5 = 32'd85569306;
  localparam logic [31:0] COEF7 = 32'd5026994;
  localparam logic [31:0] COEF9 = 32'd172272;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [SCALE_W-1:0] deriv_scale;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM0,
    ST_SQ,
    ST_HORN,
    ST_RND,
    ST_KS,
    ST_DKS,
    ST_DSIN,
    ST_DFIN,
    ST_EMC,
    ST_EMS
  } fbe_state_t;

  // coefficient for each horner step, subtracted from the product at steps 1 to 4
  function automatic logic [31:0] horner_coef(input logic [2:0] step);
    logic [31:0] c;
    case (step)
      3'd1:    c = COEF7;
      3'd2:    c = COEF5;
      3'd3:    c = COEF3;
      3'd4:    c = COEF1;
      default: c = COEF9;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/fbe_if.sv
// ----------------------------------------------------------------------------
// fbe_if
// valid/ready channels carrying the angle words and the basis term words
// ----------------------------------------------------------------------------
interface fbe_in_if import fbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase;
  logic               in_range;

  modport source (output valid, phase, in_range, input ready);
  modport sink   (input valid, phase, in_range, output ready);
endinterface

interface fbe_out_if import fbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] basis_index;
  logic [VALUE_W-1:0] value;
  logic [DERIV_W-1:0] deriv;
  logic               last;

  modport source (output valid, basis_index, value, deriv, last, input ready);
  modport sink   (input valid, basis_index, value, deriv, last, output ready);
endinterface

FILE: rtl/fbe_regs.sv
// ----------------------------------------------------------------------------
// fbe_regs
// apb configuration registers: order and derivative scale
// ----------------------------------------------------------------------------
module fbe_regs import fbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.order       <= ORDER_RST;
      cfg.deriv_scale <= SCALE_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_ORDER: cfg.order       <= pwdata[ORDER_W-1:0];
        REG_SCALE: cfg.deriv_scale <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ORDER: prdata = DATA_W'(cfg.order);
      REG_SCALE: prdata = DATA_W'(cfg.deriv_scale);
      default:   prdata = '0;
    endcase
  end

endmodule

FILE: rtl/fbe_mul.sv
// ----------------------------------------------------------------------------
// fbe_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module fbe_mul import fbe_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  mul_a,
  input  logic [MUL_W-1:0]  mul_b,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

FILE: rtl/fbe_core.sv
// ----------------------------------------------------------------------------
// fbe_core
// sequencer and datapath: phase accumulation, quarter-wave polynomial sine,
// derivative products and output word register
// ----------------------------------------------------------------------------
module fbe_core import fbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  fbe_in_if.sink            angle,
  fbe_out_if.source         terms,
  output logic [MUL_W-1:0]  mul_a,
  output logic [MUL_W-1:0]  mul_b,
  input  logic [PROD_W-1:0] prod
);

  localparam int PB = PHASE_BITS;
  localparam logic [PB-1:0] QUARTER_A = {2'b01, {(PB-2){1'b0}}};
  localparam logic [PB-2:0] QUARTER_X = {1'b1, {(PB-2){1'b0}}};
  localparam logic [PROD_W-1:0] DMAX_POS = PROD_W'(2**(DERIV_W-1) - 1);
  localparam logic [PROD_W-1:0] DMAX_NEG = PROD_W'(2**(DERIV_W-1));

  fbe_state_t state, state_next;

  logic [2:0]         hstep;
  logic [ORD_W-1:0]   harmonic_counter;
  logic [ORD_W-1:0]   ord;
  logic [PHASE_W-1:0] held_phase;
  logic               held_in_range;
  logic [PB-1:0]      ang;
  logic               do_cos;
  logic [MUL_W-1:0]   zreg;
  logic [MUL_W-1:0]   z2;
  logic               neg;
  logic [VALUE_W-1:0] sin_v;
  logic [VALUE_W-1:0] cos_v;
  logic [KS_W-1:0]    ksreg;
  logic [DERIV_W-1:0] dcos;
  logic [DERIV_W-1:0] dsin;

  logic               out_valid;
  logic [INDEX_W-1:0] out_index;
  logic [VALUE_W-1:0] out_value;
  logic [DERIV_W-1:0] out_deriv;
  logic               out_last;

  logic               out_free;
  logic               load;
  logic [PB-1:0]      sel_ang;
  logic [1:0]         quad;
  logic [PB-2:0]      xval;
  logic [MUL_W-1:0]   z_calc;
  logic [31:0]        prod_hi;
  logic [MUL_W-1:0]   t_calc;
  logic [32:0]        y_rnd;
  logic [16:0]        mag_full;
  logic [MAG_W-1:0]   mag;
  logic [VALUE_W-1:0] v_calc;
  logic [ORD_W-1:0]   ord_in;
  logic               is_last_k;

  function automatic logic [MAG_W-1:0] abs_val(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] n;
    n = -v;
    return v[VALUE_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  function automatic logic [DERIV_W-1:0] sat_deriv(input logic [PROD_W-1:0] m,
                                                   input logic              is_neg,
                                                   input logic              ok);
    logic [DERIV_W-1:0] d;
    if (!ok) begin
      d = '0;
    end else if (is_neg) begin
      d = (m > DMAX_NEG) ? {1'b1, {(DERIV_W-1){1'b0}}} : -m[DERIV_W-1:0];
    end else begin
      d = (m > DMAX_POS) ? {1'b0, {(DERIV_W-1){1'b1}}} : m[DERIV_W-1:0];
    end
    return d;
  endfunction

  assign out_free  = !out_valid || terms.ready;
  assign is_last_k = (harmonic_counter == ord);
  assign ord_in    = (cfg.order > ORDER_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER)
                                                       : ORD_W'(cfg.order);

  // quarter-wave reduction of the current angle
  assign sel_ang = do_cos ? ang + QUARTER_A : ang;
  assign quad    = sel_ang[PB-1:PB-2];
  assign xval    = quad[0] ? QUARTER_X - {1'b0, sel_ang[PB-3:0]} : {1'b0, sel_ang[PB-3:0]};
  assign z_calc  = MUL_W'(xval) << Z_SHIFT;

  assign prod_hi = prod[FRAC+31:FRAC];
  assign t_calc  = MUL_W'(horner_coef(hstep) - prod_hi);

  // round to q14, clamp and apply half-turn sign
  assign y_rnd    = {1'b0, prod_hi} + 33'd32768;
  assign mag_full = y_rnd[32:16];
  assign mag      = (mag_full > 17'(ONE_MAG)) ? ONE_MAG : mag_full[MAG_W-1:0];
  assign v_calc   = neg ? -{1'b0, mag} : {1'b0, mag};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        mul_a = z_calc;
        mul_b = z_calc;
      end
      ST_HORN: begin
        if (hstep == 3'd0) begin
          mul_a = prod[FRAC+MUL_W-1:FRAC];
          mul_b = MUL_W'(COEF9);
        end else if (hstep == 3'd4) begin
          mul_a = zreg;
          mul_b = t_calc;
        end else begin
          mul_a = z2;
          mul_b = t_calc;
        end
      end
      ST_KS: begin
        mul_a = MUL_W'(harmonic_counter);
        mul_b = MUL_W'(cfg.deriv_scale);
      end
      ST_DKS: begin
        mul_a = MUL_W'(prod[KS_W-1:0]);
        mul_b = MUL_W'(abs_val(sin_v));
      end
      ST_DSIN: begin
        mul_a = MUL_W'(ksreg);
        mul_b = MUL_W'(abs_val(cos_v));
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    case (state)
      ST_IDLE:  if (angle.valid) state_next = ST_TERM0;
      ST_TERM0: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = (ord == '0) ? ST_IDLE : ST_SQ;
        end
      end
      ST_SQ:    state_next = ST_HORN;
      ST_HORN:  if (hstep == 3'd4) state_next = ST_RND;
      ST_RND:   state_next = do_cos ? ST_KS : ST_SQ;
      ST_KS:    state_next = ST_DKS;
      ST_DKS:   state_next = ST_DSIN;
      ST_DSIN:  state_next = ST_DFIN;
      ST_DFIN:  state_next = ST_EMC;
      ST_EMC: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_EMS;
        end
      end
      ST_EMS: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = is_last_k ? ST_IDLE : ST_SQ;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hstep            <= '0;
      harmonic_counter <= '0;
      ord              <= '0;
      held_phase       <= '0;
      held_in_range    <= 1'b0;
      ang              <= '0;
      do_cos           <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (angle.valid) begin
            held_phase       <= angle.phase;
            held_in_range    <= angle.in_range;
            ord              <= ord_in;
            harmonic_counter <= ORD_W'(1);
            ang              <= PB'($unsigned(angle.phase));
            do_cos           <= 1'b0;
          end
        end
        ST_SQ:   hstep <= '0;
        ST_HORN: hstep <= hstep + 3'd1;
        ST_RND:  if (!do_cos) do_cos <= 1'b1;
        ST_EMS: begin
          if (out_free && !is_last_k) begin
            harmonic_counter <= harmonic_counter + ORD_W'(1);
            ang              <= ang + PB'($unsigned(held_phase));
            do_cos           <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SQ: begin
        zreg <= z_calc;
        neg  <= quad[1];
      end
      ST_HORN: if (hstep == 3'd0) z2 <= prod[FRAC+MUL_W-1:FRAC];
      ST_RND: begin
        if (do_cos) begin
          cos_v <= v_calc;
        end else begin
          sin_v <= v_calc;
        end
      end
      ST_DKS:  ksreg <= prod[KS_W-1:0];
      ST_DSIN: dcos  <= sat_deriv(prod, !sin_v[VALUE_W-1], held_in_range);
      ST_DFIN: dsin  <= sat_deriv(prod, cos_v[VALUE_W-1], held_in_range);
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (terms.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      case (state)
        ST_TERM0: begin
          out_index <= '0;
          out_value <= ONE_Q14;
          out_deriv <= '0;
          out_last  <= (ord == '0);
        end
        ST_EMC: begin
          out_index <= INDEX_W'({harmonic_counter, 1'b0}) - INDEX_W'(1);
          out_value <= cos_v;
          out_deriv <= dcos;
          out_last  <= 1'b0;
        end
        default: begin
          out_index <= INDEX_W'({harmonic_counter, 1'b0});
          out_value <= sin_v;
          out_deriv <= dsin;
          out_last  <= is_last_k;
        end
      endcase
    end
  end

  assign angle.ready       = (state == ST_IDLE);
  assign terms.valid       = out_valid;
  assign terms.basis_index = out_index;
  assign terms.value       = out_value;
  assign terms.deriv       = out_deriv;
  assign terms.last        = out_last;

endmodule

FILE: rtl/fourier_basis_evaluator.sv
// ----------------------------------------------------------------------------
// fourier_basis_evaluator
// For each phase word the block emits 2*order+1 basis terms, with order
// capped at 16, in index order: the constant term, then cos(k*phase) and
// sin(k*phase) in q1.14 for each harmonic k with their derivatives scaled
// by k and deriv_scale, zeroed when in_range is low, with last set on the
// final term. An angle is taken while the block is idle, the constant
// term goes out first, and each harmonic then runs through the datapath
// around the single shared 31x31 multiplier, which runs the squared
// argument, five horner steps per sine, the harmonic scale and both
// derivative products in turn (15 issues, with a rounding step after each
// sine and a saturation step), and then hands out its cosine and sine
// terms. No angle is accepted while a run is in progress.
// ----------------------------------------------------------------------------
module fourier_basis_evaluator import fbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  fbe_in_if.sink            angle,
  fbe_out_if.source         terms,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t              cfg;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  fbe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fbe_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  fbe_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .angle (angle),
    .terms (terms),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the fourier basis evaluator. Angle words go in through a
// valid/ready source with random gaps. Each accepted angle is expanded into
// its expected basis terms: a constant term, then a cosine and a sine per
// harmonic with their scaled derivatives. The terms are computed by a
// fixed-point sine model. A checker pops the oldest expected term for every
// output word and compares each field. The sink stalls at random and once
// holds off for a long stretch. The order and deriv_scale registers are
// written over apb between phases, including their extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import fbe_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int STALL_LEN   = 400;
  localparam int END_WAIT    = 60;
  localparam int IDLE_PCT    = 33;

  localparam logic [ADDR_W-1:0] ADDR_ORDER = {REG_ORDER, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SCALE = {REG_SCALE, 2'b00};

  localparam longint DERIV_HI = 64'sd134217727;
  localparam longint DERIV_LO = -64'sd134217728;
  localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(1 << (PHASE_BITS - 2));

  typedef struct packed {
    logic [INDEX_W-1:0] basis_index;
    logic [VALUE_W-1:0] value;
    logic [DERIV_W-1:0] deriv;
    logic               last;
  } basis_term_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  fbe_in_if  angle_if ();
  fbe_out_if terms_if ();

  fourier_basis_evaluator uut (
    .clk     (clk),
    .rst     (rst),
    .angle   (angle_if),
    .terms   (terms_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  basis_term_t        pending_terms[$];
  logic [ORDER_W-1:0] cur_order;
  logic [SCALE_W-1:0] cur_scale;
  logic               src_gaps   = 1'b1;
  logic               sink_gaps  = 1'b1;
  logic               stall_req  = 1'b0;
  int                 mismatches = 0;
  int                 cycle_cnt  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d terms outstanding", $time, pending_terms.size());
      $display("FAIL");
      $finish;
    end
  end

  // fixed-point sine over a quarter turn, q1.14
  function automatic int quarter_sine(int unsigned x);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] y;
    z  = 64'(x) << Z_SHIFT;
    z2 = (z * z) >> FRAC;
    t  = 64'(COEF9);
    t  = 64'(COEF7) - ((z2 * t) >> FRAC);
    t  = 64'(COEF5) - ((z2 * t) >> FRAC);
    t  = 64'(COEF3) - ((z2 * t) >> FRAC);
    t  = 64'(COEF1) - ((z2 * t) >> FRAC);
    y  = (z * t) >> FRAC;
    y  = (y + 64'd32768) >> 16;
    if (y > 64'(ONE_Q14)) y = 64'(ONE_Q14);
    return int'(y);
  endfunction

  function automatic int angle_sine(logic [PHASE_W-1:0] a);
    logic [1:0]            quad;
    logic [PHASE_W-3:0]    rem;
    int unsigned           x;
    int                    v;
    quad = a[PHASE_W-1 -: 2];
    rem  = a[PHASE_W-3:0];
    x    = quad[0] ? (int'(QUARTER_TURN) - int'(rem)) : int'(rem);
    v    = quarter_sine(x);
    return quad[1] ? -v : v;
  endfunction

  function automatic logic [DERIV_W-1:0] scaled_deriv(longint d, logic ok);
    if (!ok) return '0;
    // clamp on derivative overflow
    if (d > DERIV_HI) d = DERIV_HI;
    if (d < DERIV_LO) d = DERIV_LO;
    return d[DERIV_W-1:0];
  endfunction

  function automatic void predict_basis_terms(logic [PHASE_W-1:0] ph, logic ok);
    int          harmonics;
    logic [PHASE_W-1:0] a;
    int          s;
    int          c;
    longint      ks;
    harmonics = (cur_order > MAX_ORDER) ? MAX_ORDER : int'(cur_order);
    pending_terms.push_back('{basis_index: '0, value: ONE_Q14, deriv: '0,
                              last: (harmonics == 0)});
    for (int k = 1; k <= harmonics; k++) begin
      a  = PHASE_W'(ph * k);
      s  = angle_sine(a);
      c  = angle_sine(PHASE_W'(a + QUARTER_TURN));
      ks = longint'(k) * longint'(cur_scale);
      pending_terms.push_back('{basis_index: INDEX_W'(2 * k - 1), value: VALUE_W'(c),
                                deriv: scaled_deriv(-ks * s, ok), last: 1'b0});
      pending_terms.push_back('{basis_index: INDEX_W'(2 * k), value: VALUE_W'(s),
                                deriv: scaled_deriv(ks * c, ok), last: (k == harmonics)});
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : term_check
    basis_term_t want;
    if (!rst && terms_if.valid && terms_if.ready) begin
      if (pending_terms.size() == 0) begin
        $display("%0t unexpected term: expected none actual index %0d value %0h deriv %0h",
                 $time, terms_if.basis_index, terms_if.value, terms_if.deriv);
        mismatches++;
      end else begin
        want = pending_terms.pop_front();
        check_field("basis_index", 32'(want.basis_index), 32'(terms_if.basis_index));
        check_field("value", 32'(want.value), 32'(terms_if.value));
        check_field("deriv", 32'(want.deriv), 32'(terms_if.deriv));
        check_field("last", 32'(want.last), 32'(terms_if.last));
      end
    end
  end

  // sink side: random stalls, or one long hold-off on request
  initial begin
    terms_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        terms_if.ready = 1'b0;
        repeat (STALL_LEN - 1) @(negedge clk);
        stall_req = 1'b0;
      end else if (sink_gaps && $urandom_range(99) < IDLE_PCT) begin
        terms_if.ready = 1'b0;
      end else begin
        terms_if.ready = 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_angle(logic [PHASE_W-1:0] ph, logic ok);
    while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
      angle_if.valid    = 1'b0;
      angle_if.phase    = PHASE_W'($urandom);
      angle_if.in_range = 1'($urandom);
      @(negedge clk);
    end
    angle_if.valid    = 1'b1;
    angle_if.phase    = ph;
    angle_if.in_range = ok;
    @(posedge clk);
    while (!angle_if.ready) @(posedge clk);
    predict_basis_terms(ph, ok);
    @(negedge clk);
  endtask

  task automatic drain_terms();
    angle_if.valid = 1'b0;
    while (pending_terms.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_ORDER) cur_order = data[ORDER_W-1:0];
    else if (addr == ADDR_SCALE) cur_scale = data[SCALE_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(int unsigned order_val, int unsigned scale_val);
    drain_terms();
    apb_write(ADDR_ORDER, ($urandom & ~32'h1f) | order_val);
    apb_write(ADDR_SCALE, ($urandom & ~32'hffff) | scale_val);
  endtask

  task automatic test_reset_values();
    send_angle(16'h0000, 1'b1);
    send_angle(16'h7fff, 1'b1);
    send_angle(16'h8000, 1'b1);
    send_angle(16'hffff, 1'b1);
    send_angle(16'h4000, 1'b1);
    send_angle(16'hc000, 1'b1);
    send_angle(16'h2000, 1'b0);
  endtask

  task automatic test_order_limits();
    // order zero gives the constant term only
    set_config(0, 256);
    send_angle(16'h1234, 1'b1);
    send_angle(16'h8000, 1'b0);
    // order above max with full scale, derivatives clamp
    set_config(31, 65535);
    send_angle(16'h0800, 1'b1);
    send_angle(16'hf7ff, 1'b1);
    send_angle(16'h0800, 1'b0);
    set_config(17, 1);
    send_angle(16'h5555, 1'b1);
    set_config(1, 0);
    send_angle(16'haaaa, 1'b1);
    send_angle(16'h3fff, 1'b0);
  endtask

  task automatic test_output_stall();
    set_config(MAX_ORDER, 300);
    src_gaps  = 1'b0;
    stall_req = 1'b1;
    repeat (6) send_angle(PHASE_W'($urandom), 1'b1);
    src_gaps = 1'b1;
  endtask

  task automatic test_random_angles();
    int unsigned order_val;
    int unsigned scale_val;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       order_val = MAX_ORDER;
        1:       order_val = 0;
        2:       order_val = 31;
        default: order_val = $urandom_range(31);
      endcase
      case (p % 5)
        0:       scale_val = $urandom_range(65535);
        1:       scale_val = 65535;
        2:       scale_val = 0;
        default: scale_val = $urandom_range(1023);
      endcase
      set_config(order_val, scale_val);
      // one long stretch with no idling on either side
      src_gaps  = (p != 6);
      sink_gaps = (p != 6);
      repeat (25) send_angle(PHASE_W'($urandom), ($urandom_range(9) != 0));
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin
    rst               = 1'b1;
    angle_if.valid    = 1'b0;
    angle_if.phase    = '0;
    angle_if.in_range = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cur_order         = ORDER_RST;
    cur_scale         = SCALE_RST;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_values();
    test_order_limits();
    test_output_stall();
    test_random_angles();

    drain_terms();
    repeat (END_WAIT) @(negedge clk);
    if (mismatches == 0 && pending_terms.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: fourier_basis_evaluator.f
rtl/fbe_pkg.sv
rtl/fbe_if.sv
rtl/fbe_regs.sv
rtl/fbe_mul.sv
rtl/fbe_core.sv
rtl/fourier_basis_evaluator.sv
tb/sv/tb_top.sv
